// File: hdl/lrl_pkg.sv
package lrl_pkg;

	localparam int DEPTH     = 16;
	localparam int KEY_WIDTH = 32;
	localparam int KEY_IO_W  = 32;
	localparam int CNT_IO_W  = 5;
	localparam int CAP_W     = 5;
	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int CMP_W     = (CNT_W > CAP_W) ? CNT_W : CAP_W;
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	typedef logic [KEY_WIDTH-1:0] key_t;
	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [CMP_W-1:0]     cmp_t;

	typedef struct packed {
		logic valid;
		key_t key;
	} lrl_link_t;

	typedef struct packed {
		logic touch;
		logic read;
		logic full;
		key_t key;
	} lrl_cmd_t;

	typedef enum logic {
		ST_IDLE,
		ST_READ
	} lrl_state_t;

	function automatic key_t to_key(input logic signed [KEY_IO_W-1:0] k);
		logic signed [63:0] w;
		w = 64'(k);
		return w[KEY_WIDTH-1:0];
	endfunction

	function automatic logic [KEY_IO_W-1:0] from_key(input key_t k);
		logic [63:0] w;
		w = 64'(k);
		return w[KEY_IO_W-1:0];
	endfunction

endpackage

// File: hdl/lrl_if.sv
interface lrl_req_if;
	import lrl_pkg::*;
	logic                       valid;
	logic                       ready;
	logic signed [KEY_IO_W-1:0] request_key;
	logic                       end_of_batch;

	modport source(output valid, request_key, end_of_batch, input ready);
	modport sink(input valid, request_key, end_of_batch, output ready);
endinterface

interface lrl_rsp_if;
	import lrl_pkg::*;
	logic                       valid;
	logic                       ready;
	logic signed [KEY_IO_W-1:0] list_key;
	logic                       is_last;
	logic        [CNT_IO_W-1:0] entry_count;

	modport source(output valid, list_key, is_last, entry_count, input ready);
	modport sink(input valid, list_key, is_last, entry_count, output ready);
endinterface

// File: hdl/lru_recency_list.sv
// Recency list of up to list_capacity keys (0 acts as 1, above 16 as 16), kept in a row of
// compare-and-shift cells, most recent key in the first cell. For each request item taken, a
// hit moves its key to the front, a miss pushes the key in front and, when the
// list is full, drops the least recent key. The item flagged end_of_batch is applied, then the
// list is shifted out one entry per cycle while the sink is ready, most recent first, with
// is_last on the final entry and entry_count on every entry, and the list is left empty. No
// request is taken during that readout.
// Write list_capacity only while the block is idle.
module lru_recency_list (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [lrl_pkg::CAP_W-1:0]       cfg_wdata,
	lrl_req_if.sink                         req,
	lrl_rsp_if.source                       rsp
);
	import lrl_pkg::*;

	lrl_state_t state_q, state_d;
	logic [CAP_W-1:0] cap_q;
	cnt_t occ_q, occ_d;
	cnt_t rem_q, rem_d;
	cmp_t cap_eff;

	logic                  rsp_valid_q;
	logic [KEY_IO_W-1:0]   list_key_q;
	logic                  is_last_q;
	logic [CNT_IO_W-1:0]   entry_count_q;

	lrl_cmd_t  cmd;
	lrl_link_t cell_st [DEPTH];
	logic      hit_chain [DEPTH+1];
	logic      accept;
	logic      emit;

	always_comb begin
		if (cap_q == '0) begin
			cap_eff = CMP_W'(1);
		end else if (CMP_W'(cap_q) > CMP_W'(DEPTH)) begin
			cap_eff = CMP_W'(DEPTH);
		end else begin
			cap_eff = CMP_W'(cap_q);
		end
	end

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign emit      = (state_q == ST_READ) && (!rsp_valid_q || rsp.ready);

	assign cmd.touch = accept;
	assign cmd.read  = emit;
	assign cmd.full  = CMP_W'(occ_q) >= cap_eff;
	assign cmd.key   = to_key(req.request_key);

	assign hit_chain[0] = 1'b0;

	for (genvar j = 0; j < DEPTH; j++) begin : g_cell
		lrl_link_t prev_l;
		lrl_link_t next_l;
		if (j == 0) begin : g_head
			assign prev_l = '{valid: 1'b1, key: cmd.key};
		end else begin : g_body
			assign prev_l = cell_st[j-1];
		end
		if (j == DEPTH - 1) begin : g_tail
			assign next_l = '{valid: 1'b0, key: '0};
		end else begin : g_mid
			assign next_l = cell_st[j+1];
		end
		lrl_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmd     (cmd),
			.prev    (prev_l),
			.next    (next_l),
			.hit_in  (hit_chain[j]),
			.state   (cell_st[j]),
			.hit_out (hit_chain[j+1])
		);
	end

	always_comb begin
		state_d = state_q;
		occ_d   = occ_q;
		rem_d   = rem_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (!hit_chain[DEPTH] && !cmd.full) begin
						occ_d = occ_q + CNT_W'(1);
					end
					if (req.end_of_batch) begin
						rem_d   = occ_d;
						state_d = ST_READ;
					end
				end
			end
			ST_READ: begin
				if (emit) begin
					rem_d = rem_q - CNT_W'(1);
					if (rem_q == CNT_W'(1)) begin
						occ_d   = '0;
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			occ_q   <= '0;
			rem_q   <= '0;
			cap_q   <= CAP_RESET;
		end else begin
			state_q <= state_d;
			occ_q   <= occ_d;
			rem_q   <= rem_d;
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
		end
	end

	// hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (emit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			list_key_q    <= from_key(cell_st[0].key);
			is_last_q     <= (rem_q == CNT_W'(1));
			entry_count_q <= CNT_IO_W'(occ_q);
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.list_key    = list_key_q;
	assign rsp.is_last     = is_last_q;
	assign rsp.entry_count = entry_count_q;

endmodule

// File: hdl/lrl_cell.sv
module lrl_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  lrl_pkg::lrl_cmd_t   cmd,
	input  lrl_pkg::lrl_link_t  prev,
	input  lrl_pkg::lrl_link_t  next,
	input  logic                hit_in,
	output lrl_pkg::lrl_link_t  state,
	output logic                hit_out
);
	import lrl_pkg::*;

	logic valid_q;
	key_t key_q;
	logic match;
	logic shift;

	assign match   = valid_q && (key_q == cmd.key);
	assign hit_out = hit_in || match;
	assign shift   = cmd.touch && !hit_in && (cmd.full ? valid_q : prev.valid);
	assign state   = '{valid: valid_q, key: key_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.read) begin
			valid_q <= next.valid;
		end else if (shift) begin
			valid_q <= prev.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.read) begin
			key_q <= next.key;
		end else if (shift) begin
			key_q <= prev.key;
		end
	end

endmodule

// File: sim/tb_lru_recency_list.sv
module tb_lru_recency_list;
	import lrl_pkg::*;

	localparam int RANDOM_ITEMS = 210;
	localparam int LONG_HOLD    = 300;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int SETTLE_WAIT  = 4;

	typedef logic signed [KEY_IO_W-1:0] req_key_t;

	typedef struct {
		req_key_t            list_key;
		logic                is_last;
		logic [CNT_IO_W-1:0] entry_count;
	} list_entry_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [CAP_W-1:0] cfg_wdata = '0;

	lrl_req_if req();
	lrl_rsp_if rsp();

	lru_recency_list DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.rsp       (rsp)
	);

	req_key_t         recency_q[$];
	logic [CAP_W-1:0] capacity_reg = CAP_RESET;
	list_entry_t      readout_q[$];
	int               errors = 0;
	int               burst_left = 0;
	int               hold_requests = 0;
	int               hold_seen = 0;
	int               hold_left = 0;
	int               ready_mode = 0;
	int               mode_left = 0;
	int               cycle_count = 0;

	always #2 clk = ~clk;

	function automatic int effective_capacity();
		int c;
		c = int'(capacity_reg);
		if (c == 0) begin
			c = 1;
		end
		if (c > DEPTH) begin
			c = DEPTH;
		end
		return c;
	endfunction

	function automatic void touch_key(input req_key_t key, input logic eob);
		int          hit;
		int          n;
		list_entry_t e;
		hit = -1;
		foreach (recency_q[i]) begin
			if (recency_q[i] == key) begin
				hit = i;
			end
		end
		if (hit >= 0) begin
			recency_q.delete(hit);
		end else if (recency_q.size() >= effective_capacity()) begin
			recency_q.delete(0);
		end
		recency_q = {recency_q, key};
		if (eob) begin
			n = recency_q.size();
			for (int k = n - 1; k >= 0; k--) begin
				e.list_key    = recency_q[k];
				e.is_last     = (k == 0);
				e.entry_count = CNT_IO_W'(n);
				readout_q     = {readout_q, e};
			end
			recency_q.delete();
		end
	endfunction

	function automatic req_key_t random_key();
		case ($urandom_range(0, 11))
			0: return req_key_t'(32'h8000_0000);
			1: return req_key_t'(32'h7FFF_FFFF);
			2: return '0;
			3: return '1;
			default: return req_key_t'($urandom);
		endcase
	endfunction

	task automatic send_request(input req_key_t key, input logic eob);
		int gap;
		req.valid        <= 1'b1;
		req.request_key  <= key;
		req.end_of_batch <= eob;
		@(posedge clk);
		while (!req.ready) begin
			@(posedge clk);
		end
		touch_key(key, eob);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				req.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic wait_idle();
		req.valid <= 1'b0;
		@(posedge clk);
		while (readout_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_WAIT) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] value);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		capacity_reg = value;
	endtask

	task automatic test_key_extremes();
		send_request(req_key_t'(32'h8000_0000), 1'b0);
		send_request(req_key_t'(32'h7FFF_FFFF), 1'b0);
		send_request('0, 1'b0);
		send_request('1, 1'b0);
		send_request(req_key_t'(1), 1'b0);
		send_request(req_key_t'(32'h5555_5555), 1'b0);
		send_request(req_key_t'(32'hAAAA_AAAA), 1'b0);
		send_request(req_key_t'(32'h7FFF_FFFF), 1'b0);
		send_request(req_key_t'(32'h8000_0000), 1'b0);
		send_request('1, 1'b1);
	endtask

	task automatic test_capacity_floor();
		write_capacity('0);
		send_request(req_key_t'(5), 1'b0);
		send_request(req_key_t'(6), 1'b0);
		send_request(req_key_t'(7), 1'b1);
		write_capacity(CAP_W'(1));
		send_request(req_key_t'(8), 1'b0);
		send_request(req_key_t'(9), 1'b1);
		write_capacity('1);
		send_request(req_key_t'(-3), 1'b0);
		send_request(req_key_t'(-4), 1'b0);
		send_request(req_key_t'(-3), 1'b1);
	endtask

	task automatic test_capacity_lowered();
		write_capacity(CAP_W'(16));
		send_request(req_key_t'(11), 1'b0);
		send_request(req_key_t'(12), 1'b0);
		send_request(req_key_t'(13), 1'b0);
		send_request(req_key_t'(14), 1'b0);
		write_capacity(CAP_W'(2));
		send_request(req_key_t'(15), 1'b0);
		send_request(req_key_t'(13), 1'b0);
		send_request(req_key_t'(16), 1'b1);
		send_request(req_key_t'(42), 1'b1);
	endtask

	task automatic test_backpressure();
		write_capacity(CAP_W'(16));
		hold_requests++;
		burst_left = 40;
		for (int i = 0; i < 20; i++) begin
			send_request(random_key() ^ req_key_t'(i), i == 19);
		end
		for (int i = 0; i < 10; i++) begin
			send_request(req_key_t'($urandom_range(0, 5)), i == 9);
		end
	endtask

	task automatic test_random_batches();
		int               sent;
		int               batch_len;
		int               pool_size;
		logic [CAP_W-1:0] cap;
		req_key_t         pool[24];
		req_key_t         key;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 2) == 0) begin
				cap = CAP_W'($urandom_range(0, 1) ? $urandom_range(0, 6) :
					$urandom_range(0, 31));
				write_capacity(cap);
			end
			pool_size = $urandom_range(1, 24);
			foreach (pool[i]) begin
				pool[i] = random_key();
			end
			batch_len = ($urandom_range(0, 5) == 0) ? $urandom_range(17, 30) :
				$urandom_range(1, 12);
			for (int i = 0; i < batch_len; i++) begin
				if (i == batch_len / 2 && i > 0 && $urandom_range(0, 7) == 0) begin
					write_capacity(CAP_W'($urandom_range(1, 4)));
				end
				if ($urandom_range(0, 7) == 0) begin
					key = random_key();
				end else begin
					key = pool[$urandom_range(0, pool_size - 1)];
				end
				send_request(key, i == batch_len - 1);
				sent++;
			end
		end
	endtask

	always @(posedge clk) begin : check_readout
		list_entry_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (readout_q.size() == 0) begin
				$error("unexpected list entry: list_key=%0d", rsp.list_key);
				errors++;
			end else begin
				want = readout_q.pop_front();
				if (rsp.list_key !== want.list_key) begin
					$error("list_key: expected %0d, got %0d", want.list_key, rsp.list_key);
					errors++;
				end
				if (rsp.is_last !== want.is_last) begin
					$error("is_last: expected %0b, got %0b", want.is_last, rsp.is_last);
					errors++;
				end
				if (rsp.entry_count !== want.entry_count) begin
					$error("entry_count: expected %0d, got %0d", want.entry_count,
						rsp.entry_count);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (hold_requests != hold_seen) begin
			hold_seen = hold_requests;
			hold_left = LONG_HOLD;
		end
		if (mode_left == 0) begin
			ready_mode = $urandom_range(0, 2);
			mode_left  = $urandom_range(8, 80);
		end else begin
			mode_left--;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp.ready <= 1'b0;
		end else begin
			case (ready_mode)
				0: rsp.ready <= 1'b1;
				1: rsp.ready <= ($urandom_range(0, 3) != 0);
				default: rsp.ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		req.valid        = 1'b0;
		req.request_key  = '0;
		req.end_of_batch = 1'b0;
		rsp.ready        = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_key_extremes();
		test_capacity_floor();
		test_capacity_lowered();
		test_backpressure();
		test_random_batches();
		wait_idle();
		repeat (16) @(posedge clk);
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
